### src/assert_macros.svh
// assertion macros included by the parser top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on clk_i, off while rst_ni is low
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, checked on clk_i, off while rst_ni is low
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### src/ihmp_pkg.sv
// types, constants and helper functions of the ipv4 host/mask/port parser
package ihmp_pkg;

  typedef logic [2:0] ihmp_phase_t;

  localparam ihmp_phase_t PH_OCTET       = 3'd0;
  localparam ihmp_phase_t PH_AFTER_ADDR  = 3'd1;
  localparam ihmp_phase_t PH_PREFIX      = 3'd2;
  localparam ihmp_phase_t PH_PORT_FIRST  = 3'd3;
  localparam ihmp_phase_t PH_PORT_SECOND = 3'd4;
  localparam ihmp_phase_t PH_PORT_DEC    = 3'd5;
  localparam ihmp_phase_t PH_PORT_HEX    = 3'd6;
  localparam ihmp_phase_t PH_DONE        = 3'd7;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A_UP  = 8'h41;
  localparam logic [7:0] CH_F_UP  = 8'h46;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_F_LO  = 8'h66;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_X_LO  = 8'h78;

  localparam logic [31:0] MASK_ALL  = 32'hFFFF_FFFF;
  localparam logic [15:0] PORT_RST  = 16'd47808;
  localparam logic [7:0]  PREFIX_SAT = 8'd255;
  localparam logic [7:0]  PREFIX_MAX = 8'd31;
  localparam logic [5:0]  MASK_BITS = 6'd32;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } ihmp_in_t;

  typedef struct packed {
    logic [31:0] host;
    logic [31:0] mask;
    logic [15:0] port;
  } ihmp_out_t;

  typedef struct packed {
    ihmp_phase_t phase;
    logic [1:0]  octet_index;
    logic [7:0]  octet_value;
    logic [31:0] host_accum;
    logic [7:0]  prefix_count;
    logic        prefix_seen;
    logic [15:0] port_accum;
    logic        port_given;
  } ihmp_state_t;

  localparam ihmp_state_t STATE_CLEAR = '{
    phase: PH_OCTET, octet_index: 2'd0, octet_value: 8'd0, host_accum: 32'd0,
    prefix_count: 8'd0, prefix_seen: 1'b0, port_accum: 16'd0, port_given: 1'b0
  };

  function automatic logic is_dec(input logic [7:0] c);
    return c inside {[CH_0:CH_9]};
  endfunction

  // {valid, value} of a hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[CH_0:CH_9]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[CH_A_UP:CH_F_UP], [CH_A_LO:CH_F_LO]}) begin
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

  // octet placed at its byte lane, first octet in the top byte
  function automatic logic [31:0] pending_octet(input logic [7:0] v, input logic [1:0] idx);
    return {v, 24'd0} >> {idx, 3'd0};
  endfunction

  function automatic ihmp_phase_t after_addr(input logic [7:0] c);
    ihmp_phase_t p;
    case (c)
      CH_SLASH: p = PH_PREFIX;
      CH_COLON: p = PH_PORT_FIRST;
      default:  p = PH_DONE;
    endcase
    return p;
  endfunction

endpackage

### src/ihmp_step.sv
// per-character parse step: next parse state and the result fields
module ihmp_step (
  input  ihmp_pkg::ihmp_state_t state_i,
  input  ihmp_pkg::ihmp_in_t    item_i,
  input  logic [15:0]           default_port_i,
  output ihmp_pkg::ihmp_state_t state_o,
  output ihmp_pkg::ihmp_out_t   result_o
);
  import ihmp_pkg::*;

  ihmp_state_t s;
  logic [7:0]  c;
  logic [3:0]  dig;
  logic [4:0]  hex;
  logic [11:0] pfx_n;
  logic [11:0] oct_n;
  logic [15:0] dec_port;

  assign c   = item_i.ch;
  assign dig = c[3:0];
  assign hex = hex_digit(c);

  // times ten plus digit, as shifts and adds
  assign oct_n    = ({4'd0, state_i.octet_value} << 3) + ({4'd0, state_i.octet_value} << 1)
                  + {8'd0, dig};
  assign pfx_n    = ({4'd0, state_i.prefix_count} << 3) + ({4'd0, state_i.prefix_count} << 1)
                  + {8'd0, dig};
  assign dec_port = (state_i.port_accum << 3) + (state_i.port_accum << 1) + {12'd0, dig};

  always_comb begin
    s = state_i;
    if (c == CH_NUL) begin
      s.phase = PH_DONE;
    end else begin
      case (state_i.phase)
        PH_OCTET: begin
          if (is_dec(c)) begin
            s.octet_value = oct_n[7:0];
          end else begin
            s.host_accum  = state_i.host_accum
                          | pending_octet(state_i.octet_value, state_i.octet_index);
            s.octet_value = 8'd0;
            if (c == CH_DOT) begin
              if (state_i.octet_index == 2'd3) s.phase = PH_AFTER_ADDR;
              else s.octet_index = state_i.octet_index + 2'd1;
            end else begin
              s.phase = after_addr(c);
            end
          end
        end
        PH_AFTER_ADDR: s.phase = after_addr(c);
        PH_PREFIX: begin
          if (is_dec(c)) begin
            s.prefix_count = (pfx_n > {4'd0, PREFIX_SAT}) ? PREFIX_SAT : pfx_n[7:0];
            s.prefix_seen  = 1'b1;
          end else begin
            s.phase = (c == CH_COLON) ? PH_PORT_FIRST : PH_DONE;
          end
        end
        PH_PORT_FIRST: begin
          if (is_dec(c)) begin
            s.port_accum = {12'd0, dig};
            s.port_given = 1'b1;
            s.phase      = PH_PORT_SECOND;
          end else begin
            s.phase = PH_DONE;
          end
        end
        PH_PORT_SECOND: begin
          if (c == CH_X_UP || c == CH_X_LO) begin
            s.port_accum = 16'd0;
            s.phase      = PH_PORT_HEX;
          end else if (is_dec(c)) begin
            s.port_accum = dec_port;
            s.phase      = PH_PORT_DEC;
          end else begin
            s.phase = PH_DONE;
          end
        end
        PH_PORT_DEC: begin
          if (is_dec(c)) s.port_accum = dec_port;
          else s.phase = PH_DONE;
        end
        PH_PORT_HEX: begin
          if (hex[4]) s.port_accum = {state_i.port_accum[11:0], hex[3:0]};
          else s.phase = PH_DONE;
        end
        default: s.phase = PH_DONE;
      endcase
    end
  end

  always_comb begin
    result_o.host = s.host_accum | pending_octet(s.octet_value, s.octet_index);
    result_o.mask = MASK_ALL;
    if (s.prefix_seen && s.prefix_count != 8'd0 && s.prefix_count <= PREFIX_MAX) begin
      result_o.mask = MASK_ALL << (MASK_BITS - {1'b0, s.prefix_count[4:0]});
    end
    result_o.port = s.port_given ? s.port_accum : default_port_i;
  end

  // state clears once a result goes out
  assign state_o = item_i.last ? STATE_CLEAR : s;

endmodule

### src/ihmp_out_reg.sv
// result register with valid/stall toward the consumer
module ihmp_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  ihmp_pkg::ihmp_out_t data_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ihmp_pkg::ihmp_out_t out_data_o
);
  import ihmp_pkg::*;

  logic      valid_q, valid_d;
  ihmp_out_t data_q;

  assign free_o  = !valid_q || !out_stall_i;
  assign valid_d = load_i ? 1'b1 : (free_o ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

### src/ipv4_host_mask_port_parser_unit.sv
// top level of the ipv4 host/mask/port text parser
// throughput: one character transfer per cycle, with no bubbles while the result register
//   can take a last character's result
// result path: a last character waits in the input register, its result in the result register
// only a stalled result register holding a result can stall a last character
// reset clears parse state and valids; default_port comes up as 47808
module ipv4_host_mask_port_parser_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  // character channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ihmp_pkg::ihmp_in_t in_data_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ihmp_pkg::ihmp_out_t out_data_o,
  // default port register
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i
);
  import ihmp_pkg::*;
  `include "assert_macros.svh"

  // input register
  logic     in_valid_q, in_valid_d;
  ihmp_in_t in_q;
  logic     in_take;

  // parse state and config
  ihmp_state_t state_q, state_d;
  logic [15:0] default_port_q;

  // result path
  ihmp_out_t result;
  logic      out_free;
  logic      advance;
  logic      out_load;

  // a character without last never needs the result register, so it always moves on
  assign advance    = in_valid_q && (!in_q.last || out_free);
  assign out_load   = advance && in_q.last;
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;
  assign in_valid_d = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  // parse step on the registered character
  ihmp_step u_step (
    .state_i        (state_q),
    .item_i         (in_q),
    .default_port_i (default_port_q),
    .state_o        (state_d),
    .result_o       (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= STATE_CLEAR;
      default_port_q <= PORT_RST;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      if (cfg_we_i) begin
        default_port_q <= cfg_wdata_i;
      end
    end
  end

  // result register decouples the consumer stall from the parser
  ihmp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (out_load),
    .data_i      (result),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // a last character leaves a result behind
  `ASSERT_NXT(a_last_gives_result, out_load, out_valid_o)
  // parse state is back at its start after each result
  `ASSERT_NXT(a_state_clears, out_load,
              state_q.phase == PH_OCTET && !state_q.port_given && !state_q.prefix_seen)
  // the mask is always a run of ones from the top bit
  `ASSERT_IMP(a_mask_contig, out_valid_o,
              ((~out_data_o.mask) & ((~out_data_o.mask) + 32'd1)) == 32'd0)

endmodule

### bench/tb_ipv4_host_mask_port_parser_unit.sv
// testbench of the ipv4 host/mask/port text parser: directed strings, random strings, stalls
module tb_ipv4_host_mask_port_parser_unit;
  import ihmp_pkg::*;

  localparam int unsigned RUN_LIMIT       = 5_000_000;  // time units, far above the slowest run
  localparam int unsigned SETTLE_CYCLES   = 4;          // covers the two-stage pipeline plus margin
  localparam int unsigned HOLD_OFF_CYCLES = 100;
  localparam int unsigned TOTAL_CHARS     = 1100;       // the run sends at least this many characters

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  // block inputs, all known from time zero
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  ihmp_in_t    in_data_i   = '0;
  logic        out_stall_i = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  logic        in_stall_o;
  logic        out_valid_o;
  ihmp_out_t   out_data_o;

  // shadow copy of the parser and its default port register
  ihmp_state_t shadow_parse        = STATE_CLEAR;
  logic [15:0] shadow_default_port = PORT_RST;
  ihmp_out_t   predicted_addrs[$];

  // characters of the string being built, sent with last on the final one
  logic [7:0]  text_buf[$];
  string       hex_chars     = "0123456789abcdefABCDEF";
  string       grammar_chars = "./:xX09aF";

  // sender burst control
  bit          sender_gaps_on = 1'b1;
  int unsigned burst_left     = 0;

  // receiver stall control, owned by the stall process except for the requests and the quiet flag
  bit          receiver_quiet    = 1'b0;
  int unsigned hold_off_requests = 0;
  int unsigned hold_off_served   = 0;
  int unsigned hold_off_left     = 0;
  int unsigned mode_left         = 0;
  int unsigned stall_phase_ctr   = 0;
  stall_mode_t stall_mode        = STALL_NONE;

  // run statistics
  int unsigned mismatch_count    = 0;
  int unsigned chars_sent        = 0;
  int unsigned chars_parsed      = 0;
  int unsigned results_checked   = 0;
  int unsigned cfg_writes        = 0;
  int unsigned input_held_cycles = 0;

  ipv4_host_mask_port_parser_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // parser prediction
  // ---------------------------------------------------------------------------

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  // octet moved to its byte lane, octet 0 in the top byte
  function automatic logic [31:0] octet_lane(input logic [7:0] v, input logic [1:0] idx);
    return 32'(v) << (8 * (3 - int'(idx)));
  endfunction

  // once the address is over only a slash or a colon keeps parsing alive
  function automatic ihmp_phase_t phase_after_address(input logic [7:0] c);
    if (c == CH_SLASH) return PH_PREFIX;
    if (c == CH_COLON) return PH_PORT_FIRST;
    return PH_DONE;
  endfunction

  // advance the shadow parser by one accepted character, queue a result on last
  function automatic void parse_char(input logic [7:0] c, input logic is_last);
    logic [11:0] pfx;
    logic [4:0]  hx;
    ihmp_out_t   res;
    if (shadow_parse.phase != PH_DONE) chars_parsed++;
    if (c == CH_NUL) begin
      // a zero byte ends parsing wherever it falls
      shadow_parse.phase = PH_DONE;
    end else begin
      case (shadow_parse.phase)
        PH_OCTET: begin
          if (is_digit(c)) begin
            shadow_parse.octet_value = shadow_parse.octet_value * 8'd10 + (c - CH_0);
          end else begin
            shadow_parse.host_accum |= octet_lane(shadow_parse.octet_value,
                                                  shadow_parse.octet_index);
            shadow_parse.octet_value = 8'd0;
            if (c == CH_DOT) begin
              if (shadow_parse.octet_index == 2'd3) begin
                shadow_parse.phase = PH_AFTER_ADDR;
              end else begin
                shadow_parse.octet_index = shadow_parse.octet_index + 2'd1;
              end
            end else begin
              // early end of the address, this character may start prefix or port
              shadow_parse.phase = phase_after_address(c);
            end
          end
        end
        PH_AFTER_ADDR: begin
          shadow_parse.phase = phase_after_address(c);
        end
        PH_PREFIX: begin
          if (is_digit(c)) begin
            pfx = 12'(shadow_parse.prefix_count) * 12'd10 + 12'(c - CH_0);
            shadow_parse.prefix_count = (pfx > 12'd255) ? PREFIX_SAT : pfx[7:0];
            shadow_parse.prefix_seen  = 1'b1;
          end else begin
            shadow_parse.phase = (c == CH_COLON) ? PH_PORT_FIRST : PH_DONE;
          end
        end
        PH_PORT_FIRST: begin
          if (is_digit(c)) begin
            shadow_parse.port_accum = 16'(c - CH_0);
            shadow_parse.port_given = 1'b1;
            shadow_parse.phase      = PH_PORT_SECOND;
          end else begin
            shadow_parse.phase = PH_DONE;
          end
        end
        PH_PORT_SECOND: begin
          if (c == CH_X_LO || c == CH_X_UP) begin
            // hex marker drops the leading digit
            shadow_parse.port_accum = 16'd0;
            shadow_parse.phase      = PH_PORT_HEX;
          end else if (is_digit(c)) begin
            shadow_parse.port_accum = shadow_parse.port_accum * 16'd10 + 16'(c - CH_0);
            shadow_parse.phase      = PH_PORT_DEC;
          end else begin
            shadow_parse.phase = PH_DONE;
          end
        end
        PH_PORT_DEC: begin
          if (is_digit(c)) begin
            shadow_parse.port_accum = shadow_parse.port_accum * 16'd10 + 16'(c - CH_0);
          end else begin
            shadow_parse.phase = PH_DONE;
          end
        end
        PH_PORT_HEX: begin
          hx = 5'd0;
          if (is_digit(c)) hx = {1'b1, 4'(c - CH_0)};
          else if (c >= CH_A_LO && c <= CH_F_LO) hx = {1'b1, 4'(c - CH_A_LO + 8'd10)};
          else if (c >= CH_A_UP && c <= CH_F_UP) hx = {1'b1, 4'(c - CH_A_UP + 8'd10)};
          if (hx[4]) begin
            shadow_parse.port_accum = {shadow_parse.port_accum[11:0], hx[3:0]};
          end else begin
            shadow_parse.phase = PH_DONE;
          end
        end
        default: begin
          // parsing stopped, characters are ignored until last
        end
      endcase
    end
    if (is_last) begin
      res.host = shadow_parse.host_accum |
                 octet_lane(shadow_parse.octet_value, shadow_parse.octet_index);
      res.mask = MASK_ALL;
      if (shadow_parse.prefix_seen && shadow_parse.prefix_count != 8'd0 &&
          shadow_parse.prefix_count < 8'd32) begin
        res.mask = MASK_ALL << (32 - int'(shadow_parse.prefix_count));
      end
      res.port = shadow_parse.port_given ? shadow_parse.port_accum : shadow_default_port;
      predicted_addrs.push_back(res);
      shadow_parse = STATE_CLEAR;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic compare_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
      mismatch_count++;
    end
  endtask

  // a result transfers on an edge with valid high and stall low
  always @(posedge clk_i) begin : result_check
    ihmp_out_t want;
    if (in_valid_i && in_stall_o) input_held_cycles++;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (predicted_addrs.size() == 0) begin
        $display("%0t: result with none pending, actual host %h mask %h port %h",
                 $time, out_data_o.host, out_data_o.mask, out_data_o.port);
        mismatch_count++;
      end else begin
        want = predicted_addrs.pop_front();
        compare_field("host", want.host, out_data_o.host);
        compare_field("mask", want.mask, out_data_o.mask);
        compare_field("port", 32'(want.port), 32'(out_data_o.port));
        results_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver stall pattern
  // ---------------------------------------------------------------------------

  // picks a new stall mode when the current one runs out; a requested hold-off wins over all
  always @(posedge clk_i) begin
    stall_phase_ctr++;
    if (hold_off_requests != hold_off_served) begin
      hold_off_served = hold_off_requests;
      hold_off_left   = HOLD_OFF_CYCLES;
    end
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      mode_left  = $urandom_range(32, 200);
    end else begin
      mode_left--;
    end
    if (hold_off_left > 0) begin
      out_stall_i <= 1'b1;
      hold_off_left--;
    end else begin
      case (receiver_quiet ? STALL_NONE : stall_mode)
        STALL_NONE:     out_stall_i <= 1'b0;
        STALL_LIGHT:    out_stall_i <= ($urandom_range(0, 9) < 2);
        STALL_HEAVY:    out_stall_i <= ($urandom_range(0, 9) < 7);
        STALL_PERIODIC: out_stall_i <= (stall_phase_ctr[2:0] >= 3'd5);
        default:        out_stall_i <= 1'b0;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // character sending
  // ---------------------------------------------------------------------------

  // offer one character and hold it until the transfer, bursts separated by random gaps when gaps are on
  task automatic send_char(input logic [7:0] c, input logic is_last);
    int unsigned gap;
    if (sender_gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap        = $urandom_range(0, 6);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{ch: c, last: is_last};
    do @(posedge clk_i); while (in_stall_o);
    parse_char(c, is_last);
    chars_sent++;
  endtask

  task automatic send_text();
    int n;
    n = text_buf.size();
    for (int i = 0; i < n; i++) send_char(text_buf[i], i == n - 1);
    text_buf.delete();
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  task automatic push_num(input int v);
    push_str($sformatf("%0d", v));
  endtask

  task automatic send_str(input string s);
    push_str(s);
    send_text();
  endtask

  // grammar characters half the time, any byte otherwise
  function automatic logic [7:0] noise_byte();
    if ($urandom_range(0, 1)) return grammar_chars[$urandom_range(0, grammar_chars.len() - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  // mostly well-formed address text with random content, some of it broken
  task automatic build_random_text();
    int n_oct;
    int sel;
    int n_dig;
    if ($urandom_range(0, 19) == 0) begin
      n_dig = $urandom_range(1, 8);
      repeat (n_dig) text_buf.push_back(noise_byte());
      return;
    end
    n_oct = ($urandom_range(0, 9) < 8) ? 4 : $urandom_range(1, 3);
    for (int i = 0; i < n_oct; i++) begin
      if (i > 0) text_buf.push_back(CH_DOT);
      sel = $urandom_range(0, 10);
      if (sel < 7) begin
        push_num($urandom_range(0, 255));
      end else if (sel < 9) begin
        push_num($urandom_range(256, 99999));
      end else if (sel == 9) begin
        push_str("00");
        push_num($urandom_range(0, 9));
      end
      // else an empty octet
    end
    if (n_oct == 4 && $urandom_range(0, 9) == 0) text_buf.push_back(CH_DOT);
    if ($urandom_range(0, 1)) begin
      text_buf.push_back(CH_SLASH);
      sel = $urandom_range(0, 9);
      if (sel < 7) push_num($urandom_range(0, 32));
      else if (sel < 9) push_num($urandom_range(33, 99999));
    end
    if ($urandom_range(0, 1)) begin
      text_buf.push_back(CH_COLON);
      sel = $urandom_range(0, 9);
      if (sel < 5) begin
        push_num($urandom_range(0, 65535));
      end else if (sel < 6) begin
        push_num($urandom_range(65536, 9999999));
      end else if (sel < 9) begin
        push_num($urandom_range(0, 9));
        text_buf.push_back($urandom_range(0, 1) ? CH_X_UP : CH_X_LO);
        n_dig = $urandom_range(0, 6);
        repeat (n_dig) text_buf.push_back(hex_chars[$urandom_range(0, hex_chars.len() - 1)]);
      end
    end
    // broken sequences: a replaced character, a cut tail, or junk after the end
    sel = $urandom_range(0, 9);
    if (sel == 0 && text_buf.size() > 0) begin
      text_buf[$urandom_range(0, text_buf.size() - 1)] = noise_byte();
    end else if (sel == 1 && text_buf.size() > 1) begin
      void'(text_buf.pop_back());
    end else if (sel == 2) begin
      text_buf.push_back(CH_NUL);
      text_buf.push_back(noise_byte());
    end else if (sel == 3) begin
      repeat (3) text_buf.push_back(noise_byte());
    end
    if (text_buf.size() == 0) text_buf.push_back(noise_byte());
  endtask

  // ---------------------------------------------------------------------------
  // idle handling and the default port register
  // ---------------------------------------------------------------------------

  // stop offering, wait for every pending result, then let the pipeline settle
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (predicted_addrs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_default_port(input logic [15:0] v);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_default_port = v;
    cfg_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // lone last transfers and the port value coming out of reset
  task automatic test_reset_default();
    text_buf.push_back(CH_NUL);
    send_text();
    send_str("7");
    send_str("1.2.3.4");
  endtask

  task automatic test_address_forms();
    send_str("255.255.255.255/32:65535");
    send_str("0.0.0.0");
    send_str("256.300.1.999");
    send_str("1.2");
    send_str("1.2.3.4.5");
  endtask

  task automatic test_prefix_forms();
    send_str("/0");
    send_str("/1");
    send_str("/31");
    send_str("/99999");
    send_str("1.2/8");
    send_str("9.9.9.9/:443");
  endtask

  task automatic test_port_forms();
    send_str(":0");
    send_str(":99999");
    send_str("1.2:");
    send_str(":7");
    send_str(":0x1fAb");
    send_str(":0X");
    send_str(":0xfffff");
    send_str(":12x9");
  endtask

  // zero bytes, bytes with the top bit set and foreign characters end parsing
  task automatic test_stop_chars();
    push_str("1.2");
    text_buf.push_back(CH_NUL);
    push_str("3");
    send_text();
    push_str("1.");
    text_buf.push_back(8'hFF);
    text_buf.push_back(8'h80);
    send_text();
    send_str("10.0 ab");
  endtask

  task automatic test_port_register();
    write_default_port(16'h0000);
    send_str(":");
    send_str("1.2.3.4");
    write_default_port(16'hFFFF);
    send_str("/24");
    write_default_port(PORT_RST);
  endtask

  // receiver holds off while the sender keeps offering short strings
  task automatic test_backpressure();
    sender_gaps_on = 1'b0;
    hold_off_requests++;
    for (int i = 0; i < 40; i++) send_str($sformatf(":%0d", i * 1637));
    sender_gaps_on = 1'b1;
  endtask

  // a stretch with no idling on either side
  task automatic test_back_to_back();
    sender_gaps_on = 1'b0;
    receiver_quiet = 1'b1;
    repeat (12) begin
      build_random_text();
      send_text();
    end
    sender_gaps_on = 1'b1;
    receiver_quiet = 1'b0;
  endtask

  // random strings in four segments, each under its own default port
  task automatic test_random_strings();
    int unsigned target;
    for (int seg = 0; seg < 4; seg++) begin
      case (seg)
        0:       write_default_port(16'h0000);
        1:       write_default_port(16'hFFFF);
        2:       write_default_port(16'($urandom));
        default: write_default_port(PORT_RST);
      endcase
      // spread what is left of the character budget over the remaining segments
      target = chars_sent;
      if (TOTAL_CHARS > chars_sent) begin
        target = chars_sent + (TOTAL_CHARS - chars_sent) / (4 - seg);
      end
      while (chars_sent < target) begin
        build_random_text();
        send_text();
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_default();
    test_address_forms();
    test_prefix_forms();
    test_port_forms();
    test_stop_chars();
    test_port_register();
    test_backpressure();
    test_back_to_back();
    test_random_strings();
    drain_results();
    $display("covered %0d characters (%0d parsed), %0d results checked, %0d port writes",
             chars_sent, chars_parsed, results_checked, cfg_writes);
    $display("parser held its input back on %0d cycles, %0d long receiver hold-off(s)",
             input_held_cycles, hold_off_served);
    if (mismatch_count == 0 && predicted_addrs.size() == 0) begin
      $display("PASS ipv4_host_mask_port_parser_unit");
    end else begin
      $display("FAIL ipv4_host_mask_port_parser_unit");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("timeout with %0d results pending", predicted_addrs.size());
    $display("FAIL ipv4_host_mask_port_parser_unit");
    $finish;
  end

endmodule
